// File: rtl/multiset_frequency_h_index_unit_defines.svh
// Assertion macros for the multiset frequency h-index unit.
// All checks sample on clk_i and stay off while rst_ni is low.
`ifndef MULTISET_FREQUENCY_H_INDEX_UNIT_DEFINES_SVH
`define MULTISET_FREQUENCY_H_INDEX_UNIT_DEFINES_SVH

// Same-cycle implication.
`define MFHI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MFHI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mfhi_pkg.sv
package mfhi_pkg;

  localparam int NUM_VALUES_DEF = 1024;
  localparam int MAX_FREQ_DEF   = 1024;

  localparam int ID_W     = 10;
  localparam int H_OUT_W  = 11;
  localparam int STATUS_W = 2;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LIMIT  = 2'd2;

  typedef enum logic {
    ALU_INC,
    ALU_DEC
  } alu_op_e;

endpackage

// File: rtl/mfhi_ram.sv
module mfhi_ram #(
  parameter int DEPTH = mfhi_pkg::NUM_VALUES_DEF,
  parameter int WIDTH = 11,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read-first: a read at the written address returns the old word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mfhi_alu.sv
module mfhi_alu #(
  parameter int W = 12
) (
  input  mfhi_pkg::alu_op_e op_i,
  input  logic [W-1:0]      a_i,
  input  logic [W-1:0]      b_i,
  output logic [W-1:0]      res_o,
  output logic              ge_o
);

  always_comb begin
    case (op_i)
      mfhi_pkg::ALU_INC: res_o = a_i + W'(1);
      mfhi_pkg::ALU_DEC: res_o = a_i - W'(1);
      default:           res_o = a_i;
    endcase
  end

  assign ge_o = (a_i >= b_i);

endmodule

// File: rtl/multiset_frequency_h_index_unit.sv
// Multiset frequency h-index unit.
// Input channel (in_valid_i / in_stall_o) carries one word per update: cmd_i
// adds (0) or removes (1) one occurrence of value_id_i. Output channel
// (out_valid_o / out_stall_i) returns one word per update: h_index_o, the
// largest h with at least h distinct values occurring at least h times, and
// status_o (ok, remove of an absent value, frequency limit reached). On an
// error the tables and h stay untouched and the old h is returned.
// A sequencer walks each update through a count memory and a threshold
// memory with one shared inc/dec/compare unit: read the count, check it,
// update the threshold entry, test h against its neighbor, then hand the
// word to the output register; the next update is accepted only after that.
// A refused update skips the threshold steps. If NUM_VALUES is below 1024
// and not a power of two, a reciprocal multiply folds the identifier first.
// The input stalls while an update is in flight; the output register holds a
// finished word while the receiver stalls, and the next update may be
// accepted meanwhile. Its result waits until the register drains.
// After reset both memories are swept to zero, one entry per cycle, over
// max(NUM_VALUES, MAX_FREQ + 1) entries (1025 by default); the input stalls
// for that time.
`include "multiset_frequency_h_index_unit_defines.svh"

module multiset_frequency_h_index_unit #(
  parameter int NUM_VALUES = mfhi_pkg::NUM_VALUES_DEF,
  parameter int MAX_FREQ   = mfhi_pkg::MAX_FREQ_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [mfhi_pkg::ID_W-1:0]     value_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mfhi_pkg::H_OUT_W-1:0]  h_index_o,
  output logic [mfhi_pkg::STATUS_W-1:0] status_o
);

  // Index of the count memory, width of counts / h / threshold addresses,
  // width of threshold entries.
  localparam int IW = $clog2(NUM_VALUES);
  localparam int HW = $clog2(MAX_FREQ + 1);
  localparam int KW = HW + 1;
  localparam int TW = $clog2(NUM_VALUES + 1);
  localparam int W  = (TW > KW) ? TW : KW;

  localparam int CLR_N = (NUM_VALUES > MAX_FREQ + 1) ? NUM_VALUES : MAX_FREQ + 1;
  localparam int CLRW  = $clog2(CLR_N);

  // Identifier folding is only needed for a small, non power-of-two table.
  localparam bit NEED_FOLD = (NUM_VALUES < (1 << mfhi_pkg::ID_W)) &&
                             ((NUM_VALUES & (NUM_VALUES - 1)) != 0);
  localparam int FW = mfhi_pkg::ID_W * 2;
  // Quotient = (id * FOLD_M) >> FOLD_S, exact for every 10-bit identifier.
  localparam int FOLD_S = mfhi_pkg::ID_W * 2;
  localparam int FOLD_M = ((1 << FOLD_S) + NUM_VALUES - 1) / NUM_VALUES;
  localparam int PW     = FOLD_S + mfhi_pkg::ID_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FOLD  = 3'd2;
  localparam logic [2:0] ST_RDC   = 3'd3;
  localparam logic [2:0] ST_CHK   = 3'd4;
  localparam logic [2:0] ST_THR   = 3'd5;
  localparam logic [2:0] ST_NBR   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [CLRW-1:0] clr_q, clr_d;

  logic          cmd_q, cmd_d;
  logic [IW-1:0] id_q, id_d;
  logic [mfhi_pkg::ID_W-1:0] fold_r_q, fold_r_d;
  logic [mfhi_pkg::ID_W-1:0] fold_q_q, fold_q_d;
  logic          fold_ph_q, fold_ph_d;
  logic [HW-1:0] h_q, h_d;
  logic [HW-1:0] ta_q, ta_d;
  logic [KW-1:0] k_q, k_d;
  logic          k_ok_q, k_ok_d;
  logic          fwd_q, fwd_d;
  logic [TW-1:0] thr_new_q, thr_new_d;
  logic [mfhi_pkg::STATUS_W-1:0] sts_q, sts_d;

  logic          out_valid_q, out_valid_d;
  logic [mfhi_pkg::H_OUT_W-1:0]  out_h_q, out_h_d;
  logic [mfhi_pkg::STATUS_W-1:0] out_sts_q, out_sts_d;

  // Memory ports
  logic          cnt_we, cnt_re;
  logic [IW-1:0] cnt_waddr, cnt_raddr;
  logic [HW-1:0] cnt_wdata, cnt_rdata;
  logic          thr_we, thr_re;
  logic [HW-1:0] thr_waddr, thr_raddr;
  logic [TW-1:0] thr_wdata, thr_rdata;

  // Shared unit
  mfhi_pkg::alu_op_e alu_op;
  logic [W-1:0]  alu_a, alu_b, alu_res;
  logic          alu_ge;

  logic [PW-1:0] fold_prod;
  logic [FW-1:0] fold_ext;
  logic [FW-1:0] fold_rem;
  logic          is_add;
  logic          out_free;
  logic          chk_err;
  logic [TW-1:0] nbr_val;

  mfhi_ram #(
    .DEPTH (NUM_VALUES),
    .WIDTH (HW),
    .AW    (IW)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  mfhi_ram #(
    .DEPTH (MAX_FREQ + 1),
    .WIDTH (TW),
    .AW    (HW)
  ) u_thr_ram (
    .clk_i   (clk_i),
    .we_i    (thr_we),
    .waddr_i (thr_waddr),
    .wdata_i (thr_wdata),
    .re_i    (thr_re),
    .raddr_i (thr_raddr),
    .rdata_o (thr_rdata)
  );

  mfhi_alu #(
    .W (W)
  ) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .ge_o  (alu_ge)
  );

  assign is_add   = (cmd_q == mfhi_pkg::CMD_ADD);
  assign out_free = !out_valid_q || !out_stall_i;
  assign alu_op   = is_add ? mfhi_pkg::ALU_INC : mfhi_pkg::ALU_DEC;

  // Fold: quotient from a reciprocal multiply, then remainder = id - q * N.
  assign fold_ext  = FW'(fold_r_q);
  assign fold_prod = PW'(fold_r_q) * PW'(FOLD_M);
  assign fold_rem  = fold_ext - (FW'(fold_q_q) * FW'(NUM_VALUES));

  // An add at the frequency limit, or a remove of a zero count, is refused.
  assign chk_err = is_add ? alu_ge : (cnt_rdata == '0);

  // Threshold entry at the neighbor address, with the fresh write forwarded.
  assign nbr_val = fwd_q ? thr_new_q : thr_rdata;

  // Operand select for the shared unit
  always_comb begin
    alu_a = W'(cnt_rdata);
    alu_b = W'(MAX_FREQ);
    case (state_q)
      ST_CHK: begin
        alu_a = W'(cnt_rdata);
        alu_b = W'(MAX_FREQ);
      end
      ST_THR: begin
        alu_a = W'(thr_rdata);
        alu_b = W'(MAX_FREQ);
      end
      ST_NBR: begin
        alu_a = W'(nbr_val);
        alu_b = W'(k_q);
      end
      default: begin
        alu_a = W'(cnt_rdata);
        alu_b = W'(MAX_FREQ);
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    id_d        = id_q;
    fold_r_d    = fold_r_q;
    fold_q_d    = fold_q_q;
    fold_ph_d   = fold_ph_q;
    h_d         = h_q;
    ta_d        = ta_q;
    k_d         = k_q;
    k_ok_d      = k_ok_q;
    fwd_d       = fwd_q;
    thr_new_d   = thr_new_q;
    sts_d       = sts_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_h_d     = out_h_q;
    out_sts_d   = out_sts_q;

    cnt_we    = 1'b0;
    cnt_waddr = id_q;
    cnt_wdata = HW'(alu_res);
    cnt_re    = 1'b0;
    cnt_raddr = id_q;
    thr_we    = 1'b0;
    thr_waddr = ta_q;
    thr_wdata = TW'(alu_res);
    thr_re    = 1'b0;
    thr_raddr = ta_q;

    in_stall_o = 1'b1;

    case (state_q)
      ST_CLEAR: begin
        // Sweep both memories to zero.
        cnt_we    = ({1'b0, clr_q} < (CLRW + 1)'(NUM_VALUES));
        cnt_waddr = clr_q[IW-1:0];
        cnt_wdata = '0;
        thr_we    = ({1'b0, clr_q} < (CLRW + 1)'(MAX_FREQ + 1));
        thr_waddr = clr_q[HW-1:0];
        thr_wdata = '0;
        clr_d     = clr_q + CLRW'(1);
        if (clr_q == CLRW'(CLR_N - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_d = cmd_i;
          if (NEED_FOLD) begin
            fold_r_d  = value_id_i;
            fold_ph_d = 1'b1;
            state_d   = ST_FOLD;
          end else begin
            id_d    = IW'(value_id_i);
            state_d = ST_RDC;
          end
        end
      end

      ST_FOLD: begin
        // First phase: latch the quotient; second phase: take the remainder.
        if (fold_ph_q) begin
          fold_q_d  = fold_prod[PW-1:FOLD_S];
          fold_ph_d = 1'b0;
        end else begin
          id_d    = IW'(fold_rem);
          state_d = ST_RDC;
        end
      end

      ST_RDC: begin
        cnt_re  = 1'b1;
        state_d = ST_CHK;
      end

      ST_CHK: begin
        // Count is here: refuse, or write the new count and fetch its threshold.
        if (chk_err) begin
          sts_d   = is_add ? mfhi_pkg::STATUS_LIMIT : mfhi_pkg::STATUS_ABSENT;
          state_d = ST_DONE;
        end else begin
          sts_d     = mfhi_pkg::STATUS_OK;
          cnt_we    = 1'b1;
          ta_d      = is_add ? HW'(alu_res) : cnt_rdata;
          thr_re    = 1'b1;
          thr_raddr = ta_d;
          state_d   = ST_THR;
        end
      end

      ST_THR: begin
        // Update the threshold entry and fetch the one h is tested against.
        thr_we    = 1'b1;
        thr_new_d = TW'(alu_res);
        k_d       = is_add ? (KW'(h_q) + KW'(1)) : KW'(h_q);
        k_ok_d    = (k_d <= KW'(MAX_FREQ));
        fwd_d     = (k_d == KW'(ta_q));
        thr_re    = k_ok_d;
        thr_raddr = k_d[HW-1:0];
        state_d   = ST_NBR;
      end

      ST_NBR: begin
        if (is_add) begin
          if (k_ok_q && alu_ge) begin
            h_d = HW'(k_q);
          end
        end else if (h_q != '0 && !alu_ge) begin
          h_d = h_q - HW'(1);
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        // Hold until the output register can take the word.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_h_d     = mfhi_pkg::H_OUT_W'(h_q);
          out_sts_d   = sts_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      h_q         <= h_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    id_q        <= id_d;
    fold_r_q    <= fold_r_d;
    fold_q_q    <= fold_q_d;
    fold_ph_q   <= fold_ph_d;
    ta_q        <= ta_d;
    k_q         <= k_d;
    k_ok_q      <= k_ok_d;
    fwd_q       <= fwd_d;
    thr_new_q   <= thr_new_d;
    sts_q       <= sts_d;
    out_h_q     <= out_h_d;
    out_sts_q   <= out_sts_d;
  end

  assign out_valid_o = out_valid_q;
  assign h_index_o   = out_h_q;
  assign status_o    = out_sts_q;

  // h never passes the frequency limit.
  `MFHI_ASSERT_NOW(a_h_bound, 1'b1, KW'(h_q) <= KW'(MAX_FREQ), "h above frequency limit")
  // h moves by at most one per cycle.
  `MFHI_ASSERT_NEXT(a_h_step, 1'b1, h_q == $past(h_q) || h_q == $past(h_q) + HW'(1) || h_q == $past(h_q) - HW'(1), "h moved by more than one")
  // A new result word only comes from the done state.
  `MFHI_ASSERT_NOW(a_out_src, out_valid_q && !$past(out_valid_q), $past(state_q) == ST_DONE, "result word without done state")

endmodule
